>>> sv/jds_pkg.sv
// ----------------------------------------------------------------------------
// jds_pkg
// Widths, limits, register indexes and shared types for the joystick
// deadzone scaler.
// ----------------------------------------------------------------------------
package jds_pkg;

  // Axis lanes the design can carry
  localparam int unsigned AXIS_MAX       = 2;
  localparam int unsigned AXIS_COUNT_DEF = 2;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned DEAD_W   = 9;
  localparam int unsigned SPAN_W   = 15;
  localparam int unsigned LEVEL_W  = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  // Datapath widths
  localparam int unsigned OFF_W  = SAMPLE_W + 1;   // signed offset from centre
  localparam int unsigned DIVS_W = SAMPLE_W + 2;   // signed full - centre - dead
  localparam int unsigned MAG_W  = SAMPLE_W;       // offset magnitude after deadzone
  localparam int unsigned DIV_W  = SAMPLE_W;       // positive divisor
  localparam int unsigned PROD_W = MAG_W + SPAN_W; // unsigned product
  localparam int unsigned QUO_W  = PROD_W;         // quotient, one bit per stage

  // Pipeline depth: offset stage, product stage, divider stages, output register
  localparam int unsigned LANE_STAGES = 2 + QUO_W;
  localparam int unsigned PIPE_STAGES = LANE_STAGES + 1;

  // Saturation limits on the unsigned quotient
  localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(2 ** (LEVEL_W - 1) - 1);
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(2 ** (LEVEL_W - 1));

  typedef logic signed [LEVEL_W-1:0] level_t;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X = 4'd0,
    REG_CENTRE_Y = 4'd1,
    REG_DEAD_X   = 4'd2,
    REG_DEAD_Y   = 4'd3,
    REG_FULL_X   = 4'd4,
    REG_FULL_Y   = 4'd5,
    REG_SPAN_X   = 4'd6,
    REG_SPAN_Y   = 4'd7
  } reg_idx_e;

endpackage

>>> sv/jds_sample_if.sv
// ----------------------------------------------------------------------------
// jds_sample_if
// Input channel: one pair of raw converter samples per transaction.
// ----------------------------------------------------------------------------
interface jds_sample_if import jds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_x;
  logic [SAMPLE_W-1:0] sample_y;

  modport source (output valid, output sample_x, output sample_y, input ready);
  modport sink   (input valid, input sample_x, input sample_y, output ready);
endinterface

>>> sv/jds_level_if.sv
// ----------------------------------------------------------------------------
// jds_level_if
// Output channel: scaled axis levels and divisor error flags.
// ----------------------------------------------------------------------------
interface jds_level_if import jds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  level_x;
  logic [LEVEL_W-1:0]  level_y;
  logic [AXIS_MAX-1:0] bad_divisor;

  modport source (output valid, output level_x, output level_y, output bad_divisor,
                  input ready);
  modport sink   (input valid, input level_x, input level_y, input bad_divisor,
                  output ready);
endinterface

>>> sv/jds_cfg_if.sv
// ----------------------------------------------------------------------------
// jds_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface jds_cfg_if import jds_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/jds_pipe_ctl.sv
// ----------------------------------------------------------------------------
// jds_pipe_ctl
// Valid bits and per-stage load enables for the scaler pipeline.
// ----------------------------------------------------------------------------
module jds_pipe_ctl import jds_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_ready_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  output logic [PIPE_STAGES-1:0] stage_en_o
);

  logic [PIPE_STAGES-1:0] valid_q;
  logic [PIPE_STAGES-1:0] valid_d;

  // A stage may load when it or any stage after it holds a bubble,
  // or the output transaction completes.
  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_en
    assign stage_en_o[k] = out_ready_i | ~(&valid_q[PIPE_STAGES-1:k]);
  end

  always_comb begin
    valid_d = valid_q;
    if (stage_en_o[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < PIPE_STAGES; k++) begin
      if (stage_en_o[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = stage_en_o[0];
  assign out_valid_o = valid_q[PIPE_STAGES-1];

endmodule

>>> sv/jds_lane.sv
// ----------------------------------------------------------------------------
// jds_lane
// One axis: centre offset and deadzone, span multiply, restoring divider
// with one quotient bit per stage, and saturation.
// ----------------------------------------------------------------------------
module jds_lane import jds_pkg::*; (
  input  logic                   clk_i,
  input  logic [LANE_STAGES-1:0] stage_en_i,
  input  logic [SAMPLE_W-1:0]    sample_i,
  input  logic [SAMPLE_W-1:0]    centre_i,
  input  logic [DEAD_W-1:0]      dead_i,
  input  logic [SAMPLE_W-1:0]    full_i,
  input  logic [SPAN_W-1:0]      span_i,
  output level_t                 level_o,
  output logic                   bad_o
);

  // Divisor from configuration; stable while transactions are in flight
  logic signed [DIVS_W-1:0] divs;
  logic [DIV_W-1:0]         dv;

  assign divs  = $signed({2'b00, full_i}) - $signed({2'b00, centre_i})
               - $signed({3'b000, dead_i});
  assign bad_o = divs[DIVS_W-1] || (divs == '0);
  assign dv    = divs[DIV_W-1:0];

  // Offset stage
  logic signed [OFF_W-1:0] off;
  logic [OFF_W-1:0]        mag;
  logic [OFF_W-1:0]        magd;
  logic                    neg0_q;
  logic                    zero0_q;
  logic [MAG_W-1:0]        mag0_q;

  assign off  = $signed({1'b0, sample_i}) - $signed({1'b0, centre_i});
  assign mag  = off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
  assign magd = mag - {2'b00, dead_i};

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      neg0_q  <= off[OFF_W-1];
      zero0_q <= (mag <= {2'b00, dead_i});
      mag0_q  <= magd[MAG_W-1:0];
    end
  end

  // Product stage
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] prod1_q;
  logic              neg1_q;
  logic              zero1_q;

  assign prod_d = {{SPAN_W{1'b0}}, mag0_q} * {{MAG_W{1'b0}}, span_i};

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      prod1_q <= prod_d;
      neg1_q  <= neg0_q;
      zero1_q <= zero0_q;
    end
  end

  // Divider stages: shift one dividend bit into the remainder, subtract
  // when it fits, shift the quotient bit into the low end.
  logic [DIV_W-1:0] rem_q  [QUO_W];
  logic [QUO_W-1:0] dq_q   [QUO_W];
  logic             neg_q  [QUO_W];
  logic             zero_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [DIV_W-1:0] rem_in;
    logic [QUO_W-1:0] dq_in;
    logic             neg_in;
    logic             zero_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = prod1_q;
      assign neg_in  = neg1_q;
      assign zero_in = zero1_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign dq_in   = dq_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    assign trial = {rem_in, dq_in[QUO_W-1]};
    assign ge    = trial >= {1'b0, dv};
    assign diff  = trial - {1'b0, dv};

    always_ff @(posedge clk_i) begin
      if (stage_en_i[2+k]) begin
        rem_q[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq_q[k]   <= {dq_in[QUO_W-2:0], ge};
        neg_q[k]  <= neg_in;
        zero_q[k] <= zero_in;
      end
    end
  end

  // Sign and saturation
  logic [QUO_W-1:0] quo;

  assign quo = dq_q[QUO_W-1];

  always_comb begin
    priority if (bad_o || zero_q[QUO_W-1]) begin
      level_o = '0;
    end else if (!neg_q[QUO_W-1]) begin
      level_o = (quo > POS_LIM) ? level_t'(POS_LIM) : level_t'(quo[LEVEL_W-1:0]);
    end else begin
      level_o = (quo > NEG_LIM) ? level_t'(NEG_LIM) : level_t'(-quo[LEVEL_W-1:0]);
    end
  end

endmodule

>>> sv/jds_merge.sv
// ----------------------------------------------------------------------------
// jds_merge
// Output register: gathers the lane levels and divisor flags into one
// result, zero for axes that are not built.
// ----------------------------------------------------------------------------
module jds_merge import jds_pkg::*; #(
  parameter int unsigned AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  level_t                lane_level_i [AXIS_COUNT],
  input  logic [AXIS_COUNT-1:0] lane_bad_i,
  output level_t                level_o      [AXIS_MAX],
  output logic [AXIS_MAX-1:0]   bad_o
);

  for (genvar a = 0; a < AXIS_MAX; a++) begin : g_axis
    if (a < AXIS_COUNT) begin : g_live
      level_t level_q;
      logic   bad_q;

      always_ff @(posedge clk_i) begin
        if (load_i) begin
          level_q <= lane_level_i[a];
          bad_q   <= lane_bad_i[a];
        end
      end

      assign level_o[a] = level_q;
      assign bad_o[a]   = bad_q;
    end else begin : g_absent
      assign level_o[a] = '0;
      assign bad_o[a]   = 1'b0;
    end
  end

endmodule

>>> sv/joystick_deadzone_scaler_core.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_scaler_core
// Two-axis joystick deadzone removal and span scaling, one lane per axis.
// ----------------------------------------------------------------------------
// Each input transaction carries one raw sample per axis. Per axis the block
// forms the signed offset from centre, returns zero inside the deadzone,
// otherwise pulls the offset toward zero by the deadzone, multiplies by span
// and divides by (full - centre - dead), truncating toward zero, and
// saturates to signed 16 bits. A divisor of zero or less forces that axis to
// zero and sets its bad_divisor bit. The block takes one transaction per
// cycle while its first stage can load; each result passes through the
// offset stage, the multiply stage, a 25-stage restoring divider that
// retires one quotient bit per stage, and the output register. Stalls
// on the output only back up as far as the first empty stage, so the input
// keeps accepting while the pipeline has bubbles. Configuration registers
// take effect for samples accepted after the write; write them only while
// no transaction is in flight. Register indexes 8 and above are ignored and
// write data above a register's width is dropped.
// ----------------------------------------------------------------------------
module joystick_deadzone_scaler_core import jds_pkg::*; #(
  parameter int unsigned AXIS_COUNT = AXIS_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  jds_sample_if.sink  sample_i,
  jds_level_if.source level_o,
  jds_cfg_if.sink     cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers, one set per axis
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] centre_q [AXIS_MAX];
  logic [DEAD_W-1:0]   dead_q   [AXIS_MAX];
  logic [SAMPLE_W-1:0] full_q   [AXIS_MAX];
  logic [SPAN_W-1:0]   span_q   [AXIS_MAX];

  // Always take writes; unknown indexes fall through and are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < AXIS_MAX; a++) begin
        centre_q[a] <= SAMPLE_W'(512);
        dead_q[a]   <= '0;
        full_q[a]   <= SAMPLE_W'(1023);
        span_q[a]   <= SPAN_W'(1000);
      end
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CENTRE_X: centre_q[0] <= cfg_i.data[SAMPLE_W-1:0];
        REG_CENTRE_Y: centre_q[1] <= cfg_i.data[SAMPLE_W-1:0];
        REG_DEAD_X:   dead_q[0]   <= cfg_i.data[DEAD_W-1:0];
        REG_DEAD_Y:   dead_q[1]   <= cfg_i.data[DEAD_W-1:0];
        REG_FULL_X:   full_q[0]   <= cfg_i.data[SAMPLE_W-1:0];
        REG_FULL_Y:   full_q[1]   <= cfg_i.data[SAMPLE_W-1:0];
        REG_SPAN_X:   span_q[0]   <= cfg_i.data[SPAN_W-1:0];
        REG_SPAN_Y:   span_q[1]   <= cfg_i.data[SPAN_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: valid bit per stage, load enable per stage
  // --------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] stage_en;

  jds_pipe_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .out_ready_i (level_o.ready),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (level_o.valid),
    .stage_en_o  (stage_en)
  );

  // --------------------------------------------------------------------------
  // Axis lanes: identical datapaths, advanced by the shared enables
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]   sample [AXIS_MAX];
  level_t                lane_level [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] lane_bad;

  assign sample[0] = sample_i.sample_x;
  assign sample[1] = sample_i.sample_y;

  for (genvar a = 0; a < AXIS_COUNT; a++) begin : g_lane
    jds_lane u_lane (
      .clk_i      (clk_i),
      .stage_en_i (stage_en[LANE_STAGES-1:0]),
      .sample_i   (sample[a]),
      .centre_i   (centre_q[a]),
      .dead_i     (dead_q[a]),
      .full_i     (full_q[a]),
      .span_i     (span_q[a]),
      .level_o    (lane_level[a]),
      .bad_o      (lane_bad[a])
    );
  end

  // --------------------------------------------------------------------------
  // Merge lanes into the output register
  // --------------------------------------------------------------------------
  level_t              out_level [AXIS_MAX];
  logic [AXIS_MAX-1:0] out_bad;

  jds_merge #(
    .AXIS_COUNT (AXIS_COUNT)
  ) u_merge (
    .clk_i        (clk_i),
    .load_i       (stage_en[PIPE_STAGES-1]),
    .lane_level_i (lane_level),
    .lane_bad_i   (lane_bad),
    .level_o      (out_level),
    .bad_o        (out_bad)
  );

  assign level_o.level_x     = out_level[0];
  assign level_o.level_y     = out_level[1];
  assign level_o.bad_divisor = out_bad;

endmodule
